>>> sv/mph_pkg.sv
package mph_pkg;

	// default dimensions
	localparam int MAX_LAYERS_DEF  = 4;
	localparam int MAX_NEURONS_DEF = 16;
	// number of layer size registers
	localparam int SIZE_REGS       = 4;

	// func codes of an input word
	localparam logic [1:0] FN_WEIGHT  = 2'd0;
	localparam logic [1:0] FN_BARRIER = 2'd1;
	localparam logic [1:0] FN_DATA    = 2'd2;
	localparam logic [1:0] FN_UNUSED  = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_LAYER_COUNT = 3'd0;
	localparam logic [2:0] CFG_SIZE_ZERO   = 3'd1;
	localparam logic [2:0] CFG_SIZE_ONE    = 3'd2;
	localparam logic [2:0] CFG_SIZE_TWO    = 3'd3;
	localparam logic [2:0] CFG_SIZE_THREE  = 3'd4;

	typedef struct packed {
		logic [1:0]  func;
		logic [1:0]  layer_sel;
		logic [3:0]  row_sel;
		logic [3:0]  col_sel;
		logic [31:0] value;
		logic        last_word;
	} in_word_t;

	typedef struct packed {
		logic [31:0] out_word;
		logic        out_last;
	} out_word_t;

	// store write strobes
	typedef struct packed {
		logic w_we;
		logic b_we;
	} wr_en_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_REM_A,
		ST_REM_B,
		ST_MULT,
		ST_REM_C,
		ST_WRITE,
		ST_EMIT
	} state_t;

	// clamp a layer size into 1..hi
	function automatic logic [4:0] sat_size(input logic [4:0] s, input logic [4:0] hi);
		logic [4:0] r;
		r = s;
		if (r == 5'd0) r = 5'd1;
		if (r > hi) r = hi;
		return r;
	endfunction

	// clamp the layer count into 2..hi
	function automatic logic [2:0] sat_layers(input logic [2:0] n, input logic [2:0] hi);
		logic [2:0] r;
		r = n;
		if (r < 3'd2) r = 3'd2;
		if (r > hi) r = hi;
		return r;
	endfunction

	function automatic logic [31:0] swap_bytes(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

>>> sv/mph_store.sv
module mph_store import mph_pkg::*; #(
	parameter int MAX_LAYERS  = MAX_LAYERS_DEF,
	parameter int MAX_NEURONS = MAX_NEURONS_DEF,
	localparam int WD = (MAX_LAYERS - 1) * MAX_NEURONS * MAX_NEURONS,
	localparam int BD = MAX_LAYERS * MAX_NEURONS,
	localparam int WA = (WD > 1) ? $clog2(WD) : 1,
	localparam int BA = (BD > 1) ? $clog2(BD) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  wr_en_t        wr,
	input  logic [WA-1:0] w_waddr,
	input  logic [BA-1:0] b_waddr,
	input  logic [31:0]   wdata,
	input  logic [WA-1:0] w_raddr,
	input  logic [BA-1:0] b_raddr,
	output logic [31:0]   w_rdata,
	output logic [31:0]   b_rdata,
	output logic          clearing
);

	localparam int DEPTH = (WD > BD) ? WD : BD;
	localparam int DA    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [31:0]   wmem [WD];
	logic [31:0]   bmem [BD];
	logic [DA-1:0] clr_ptr_q;
	logic          clearing_q;

	// clearing sweep after reset, one entry of each store per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ptr_q  <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (int'(clr_ptr_q) == DEPTH - 1) clearing_q <= 1'b0;
			clr_ptr_q <= clr_ptr_q + 1'b1;
		end
	end

	assign clearing = clearing_q;

	// weight memory
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			if (int'(clr_ptr_q) < WD) wmem[WA'(clr_ptr_q)] <= '0;
		end else if (wr.w_we) begin
			wmem[w_waddr] <= wdata;
		end
		w_rdata <= wmem[w_raddr];
	end

	// barrier memory
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			if (int'(clr_ptr_q) < BD) bmem[BA'(clr_ptr_q)] <= '0;
		end else if (wr.b_we) begin
			bmem[b_waddr] <= wdata;
		end
		b_rdata <= bmem[b_raddr];
	end

endmodule

>>> sv/mph_rem.sv
module mph_rem import mph_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [31:0] rem
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] dvd_q;
	logic [31:0] dvs_q;
	logic [31:0] rem_q;
	logic [32:0] trial;
	logic        fits;

	// restoring remainder, one dividend bit per cycle
	assign trial = {rem_q, dvd_q[63]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and partial remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			rem_q <= fits ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> sv/mph_core.sv
module mph_core import mph_pkg::*; #(
	parameter int MAX_LAYERS  = MAX_LAYERS_DEF,
	parameter int MAX_NEURONS = MAX_NEURONS_DEF,
	localparam int WD = (MAX_LAYERS - 1) * MAX_NEURONS * MAX_NEURONS,
	localparam int BD = MAX_LAYERS * MAX_NEURONS,
	localparam int WA = (WD > 1) ? $clog2(WD) : 1,
	localparam int BA = (BD > 1) ? $clog2(BD) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [4:0]    cfg_data,
	input  logic          in_valid,
	output logic          in_ready,
	input  in_word_t      in_data,
	output wr_en_t        wr,
	output logic [WA-1:0] w_waddr,
	output logic [BA-1:0] b_waddr,
	output logic [WA-1:0] w_raddr,
	output logic [BA-1:0] b_raddr,
	input  logic [31:0]   w_rdata,
	input  logic [31:0]   b_rdata,
	input  logic          clearing,
	output logic          emit_valid,
	input  logic          emit_ready,
	output out_word_t     emit
);

	localparam int LANES     = (MAX_NEURONS < 16) ? MAX_NEURONS : 16;
	localparam int LAYER_CAP = (MAX_LAYERS < SIZE_REGS) ? MAX_LAYERS : SIZE_REGS;
	localparam int LW        = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int CW        = $clog2(LANES + 1);

	state_t        state_q, state_d;
	logic [2:0]    lc_q;
	logic [4:0]    sz_q [SIZE_REGS];
	logic [CW-1:0] cnt_q;
	logic [31:0]   inbuf_q [LANES];
	logic [31:0]   act_q [2][LANES];
	logic [1:0]    i_q;
	logic [LW-1:0] j_q, k_q;
	logic          v_s1, v_s2;
	logic [31:0]   a_s1;
	logic [63:0]   p_s2;
	logic [63:0]   acc_q;
	logic [31:0]   r1_q, r2_q, res_q;

	logic [2:0]    nl;
	logic [4:0]    eff0, cur_n, nxt_n, cur_m1, nxt_m1;
	logic          j_last, k_last, layer_last, drained, accept;
	logic [31:0]   act_rd;
	logic          acc_clr, rem_start, rem_busy, rem_done;
	logic [63:0]   rem_dvd;
	logic [31:0]   rem_out;

	// effective sizes
	assign nl         = sat_layers(lc_q, 3'(LAYER_CAP));
	assign eff0       = sat_size(sz_q[0], 5'(LANES));
	assign cur_n      = sat_size(sz_q[i_q], 5'(LANES));
	assign nxt_n      = sat_size(sz_q[2'(i_q + 2'd1)], 5'(LANES));
	assign cur_m1     = cur_n - 5'd1;
	assign nxt_m1     = nxt_n - 5'd1;
	assign j_last     = j_q == cur_m1[LW-1:0];
	assign k_last     = k_q == nxt_m1[LW-1:0];
	assign layer_last = (3'(i_q) + 3'd2) == nl;
	assign drained    = !v_s1 && !v_s2;
	assign accept     = in_valid && in_ready;

	// activation of source neuron j; missing input words read as zero
	always_comb begin
		if (i_q == 2'd0)
			act_rd = (CW'(j_q) < cnt_q) ? inbuf_q[j_q] : 32'd0;
		else
			act_rd = act_q[i_q[0]][j_q];
	end

	// store addressing
	assign w_raddr = WA'((int'(i_q) * MAX_NEURONS + int'(j_q)) * MAX_NEURONS + int'(k_q));
	assign b_raddr = BA'((int'(i_q) + 1) * MAX_NEURONS + int'(k_q));
	assign w_waddr = WA'((int'(in_data.layer_sel) * MAX_NEURONS + int'(in_data.row_sel))
		* MAX_NEURONS + int'(in_data.col_sel));
	assign b_waddr = BA'(int'(in_data.layer_sel) * MAX_NEURONS + int'(in_data.row_sel));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept && in_data.func == FN_DATA && in_data.last_word)
				state_d = ST_MAC;
			ST_MAC:   if (j_last) state_d = ST_DRAIN;
			ST_DRAIN: if (drained) state_d = (b_rdata == 32'd0) ? ST_WRITE : ST_REM_A;
			ST_REM_A: if (rem_done) state_d = ST_REM_B;
			ST_REM_B: if (rem_done) state_d = ST_MULT;
			ST_MULT:  state_d = ST_REM_C;
			ST_REM_C: if (rem_done) state_d = ST_WRITE;
			ST_WRITE: state_d = (k_last && layer_last) ? ST_EMIT : ST_MAC;
			ST_EMIT:  if (emit_ready && k_last) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs and strobes
	always_comb begin
		in_ready   = 1'b0;
		acc_clr    = 1'b0;
		rem_start  = 1'b0;
		rem_dvd    = acc_q + 64'd2;
		emit_valid = 1'b0;
		wr         = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = !clearing;
				acc_clr  = 1'b1;
				wr.w_we  = accept && in_data.func == FN_WEIGHT
					&& int'(in_data.layer_sel) < MAX_LAYERS - 1
					&& int'(in_data.row_sel) < MAX_NEURONS
					&& int'(in_data.col_sel) < MAX_NEURONS;
				wr.b_we  = accept && in_data.func == FN_BARRIER
					&& int'(in_data.layer_sel) < MAX_LAYERS
					&& int'(in_data.row_sel) < MAX_NEURONS;
			end
			ST_DRAIN: rem_start = drained && b_rdata != 32'd0;
			ST_REM_A: begin
				rem_start = rem_done;
				rem_dvd   = acc_q + 64'd3;
			end
			ST_MULT: begin
				rem_start = 1'b1;
				rem_dvd   = r1_q * r2_q;
			end
			ST_WRITE: acc_clr = 1'b1;
			ST_EMIT:  emit_valid = 1'b1;
			default: ;
		endcase
	end

	assign emit.out_word = swap_bytes(act_q[~i_q[0]][k_q]);
	assign emit.out_last = k_last;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lc_q    <= 3'd3;
			for (int n = 0; n < SIZE_REGS; n++) sz_q[n] <= 5'd16;
			cnt_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= state_q == ST_MAC;
			v_s2    <= v_s1;
			if (cfg_we) begin
				case (cfg_index)
					CFG_LAYER_COUNT: lc_q    <= cfg_data[2:0];
					CFG_SIZE_ZERO:   sz_q[0] <= cfg_data;
					CFG_SIZE_ONE:    sz_q[1] <= cfg_data;
					CFG_SIZE_TWO:    sz_q[2] <= cfg_data;
					CFG_SIZE_THREE:  sz_q[3] <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && in_data.func == FN_DATA) begin
						if (5'(cnt_q) < eff0) cnt_q <= cnt_q + 1'b1;
						i_q <= '0;
						j_q <= '0;
						k_q <= '0;
					end
				end
				ST_MAC: if (!j_last) j_q <= j_q + 1'b1;
				ST_WRITE: begin
					j_q <= '0;
					if (!k_last) begin
						k_q <= k_q + 1'b1;
					end else begin
						k_q <= '0;
						if (!layer_last) i_q <= i_q + 2'd1;
					end
				end
				ST_EMIT: begin
					if (emit_ready) begin
						if (k_last) cnt_q <= '0;
						else k_q <= k_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && in_data.func == FN_DATA
			&& 5'(cnt_q) < eff0)
			inbuf_q[cnt_q[LW-1:0]] <= in_data.value;
		a_s1 <= act_rd;
		p_s2 <= a_s1 * w_rdata;
		if (acc_clr) acc_q <= '0;
		else if (v_s2) acc_q <= acc_q + p_s2;
		if (state_q == ST_REM_A && rem_done) r1_q <= rem_out;
		if (state_q == ST_REM_B && rem_done) r2_q <= rem_out;
		if (state_q == ST_REM_C && rem_done) res_q <= rem_out;
		if (state_q == ST_DRAIN && drained && b_rdata == 32'd0) res_q <= '0;
		if (state_q == ST_WRITE) act_q[~i_q[0]][k_q] <= res_q;
	end

	mph_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (rem_dvd),
		.divisor  (b_rdata),
		.busy     (rem_busy),
		.done     (rem_done),
		.rem      (rem_out)
	);

	// the divider is only started when idle
	a_rem_free: assert property (@(posedge clk) disable iff (!arst_n)
		rem_start |-> !rem_busy) else $error("divider started while busy");

	// stores are only written between hashes and after clearing
	a_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.w_we || wr.b_we) |-> (state_q == ST_IDLE && !clearing))
		else $error("store write during evaluation");

	// products only reach the accumulator while a neuron is summed
	a_mac_win: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == ST_MAC || state_q == ST_DRAIN))
		else $error("stray product");

endmodule

>>> sv/modular_perceptron_hash_unit.sv
// channel | dir | signals                          | word
// config  | in  | cfg_we, cfg_index, cfg_data      | one register write, no wait
// input   | in  | in_valid, in_ready, in_data      | weight, barrier or data word
// output  | out | out_valid, out_ready, out_data   | byte-swapped final neuron value
//
// Load and data words are taken one a cycle while the block is idle.
// A last data word starts evaluation; each neuron takes a MAC per source neuron,
// a drain, two serial remainders, a multiply, a third remainder and a write; a zero
// barrier skips from drain to write. Then one result word is emitted per cycle,
// held while the output register is stalled. After reset both stores are swept to
// zero, one entry a cycle; in_ready is low meanwhile.
module modular_perceptron_hash_unit import mph_pkg::*; #(
	parameter int MAX_LAYERS  = MAX_LAYERS_DEF,
	parameter int MAX_NEURONS = MAX_NEURONS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [4:0] cfg_data,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	localparam int WD = (MAX_LAYERS - 1) * MAX_NEURONS * MAX_NEURONS;
	localparam int BD = MAX_LAYERS * MAX_NEURONS;
	localparam int WA = (WD > 1) ? $clog2(WD) : 1;
	localparam int BA = (BD > 1) ? $clog2(BD) : 1;

	wr_en_t        wr;
	logic [WA-1:0] w_waddr, w_raddr;
	logic [BA-1:0] b_waddr, b_raddr;
	logic [31:0]   w_rdata, b_rdata;
	logic          clearing;
	logic          emit_valid, emit_ready;
	out_word_t     emit;
	logic          ov_q;
	out_word_t     od_q;

	mph_store #(
		.MAX_LAYERS  (MAX_LAYERS),
		.MAX_NEURONS (MAX_NEURONS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.w_waddr  (w_waddr),
		.b_waddr  (b_waddr),
		.wdata    (in_data.value),
		.w_raddr  (w_raddr),
		.b_raddr  (b_raddr),
		.w_rdata  (w_rdata),
		.b_rdata  (b_rdata),
		.clearing (clearing)
	);

	mph_core #(
		.MAX_LAYERS  (MAX_LAYERS),
		.MAX_NEURONS (MAX_NEURONS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.wr         (wr),
		.w_waddr    (w_waddr),
		.b_waddr    (b_waddr),
		.w_raddr    (w_raddr),
		.b_raddr    (b_raddr),
		.w_rdata    (w_rdata),
		.b_rdata    (b_rdata),
		.clearing   (clearing),
		.emit_valid (emit_valid),
		.emit_ready (emit_ready),
		.emit       (emit)
	);

	// output register
	assign emit_ready = !ov_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit_valid && emit_ready) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_valid && emit_ready) od_q <= emit;
	end

	assign out_valid = ov_q;
	assign out_data  = od_q;

endmodule
